/* hdl/tep_pkg.sv */
// tep_pkg: shared types, constants and codes for the texture edge padding block
// used by every module under hdl; depends on nothing
package tep_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int PIXEL_BITS  = 32;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int X_BITS      = $clog2(MAX_WIDTH);
  localparam int Y_BITS      = $clog2(MAX_HEIGHT);
  localparam int W_BITS      = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS      = $clog2(MAX_HEIGHT + 1);

  localparam int INDEX_BITS  = 14;
  localparam int VALUE_BITS  = 32;
  localparam int REG_BITS    = 32;
  localparam int PASS_BITS   = 4;

  localparam logic [7:0]           WIDTH_RESET  = 8'd128;
  localparam logic [7:0]           HEIGHT_RESET = 8'd128;
  localparam logic [31:0]          ALPHA_RESET  = 32'h0000_00FF;
  localparam logic [PASS_BITS-1:0] PASSES_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ALPHA  = 2'd2,
    REG_PASSES = 2'd3
  } reg_index_t;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [1:0] {
    DIR_E,
    DIR_W,
    DIR_S,
    DIR_N
  } dir_t;

  typedef enum logic [1:0] {
    BASE_HOLD,
    BASE_CLEAR,
    BASE_ADD_W,
    BASE_SUB_W
  } base_op_t;

  typedef struct packed {
    logic [W_BITS-1:0]     width;
    logic [H_BITS-1:0]     height;
    logic [PIXEL_BITS-1:0] keep;
    logic [PASS_BITS-1:0]  passes;
  } cfg_t;

  typedef struct packed {
    logic              load_we;
    logic              host_rd;
    logic              pad_rd;
    logic              pad_wr;
    logic              res_read;
    logic              res_done;
    dir_t              dir;
    base_op_t          base_op;
    logic [X_BITS-1:0] x;
  } dp_cmd_t;

endpackage

/* hdl/tep_regs.sv */
// tep_regs: configuration registers and the clamped geometry and keep mask
// depends on tep_pkg
module tep_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [1:0]                    reg_index,
  input  logic [tep_pkg::REG_BITS-1:0]  write_data,
  output tep_pkg::cfg_t                 cfg
);
  import tep_pkg::*;

  logic [7:0]           image_width;
  logic [7:0]           image_height;
  logic [31:0]          alpha_mask;
  logic [PASS_BITS-1:0] pass_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      alpha_mask   <= ALPHA_RESET;
      pass_count   <= PASSES_RESET;
    end else if (write_enable) begin
      case (reg_index)
        REG_WIDTH:  image_width  <= write_data[7:0];
        REG_HEIGHT: image_height <= write_data[7:0];
        REG_ALPHA:  alpha_mask   <= write_data[31:0];
        REG_PASSES: pass_count   <= write_data[PASS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = (int'(image_width) > MAX_WIDTH) ? W_BITS'(MAX_WIDTH) : W_BITS'(image_width);
    cfg.height = (int'(image_height) > MAX_HEIGHT) ? H_BITS'(MAX_HEIGHT)
                                                   : H_BITS'(image_height);
    cfg.keep   = ~alpha_mask[PIXEL_BITS-1:0];
    cfg.passes = pass_count;
  end

endmodule

/* hdl/tep_ctrl.sv */
// tep_ctrl: command decode and the sweep sequencer for padding passes
// depends on tep_pkg; drives tep_dp through dp_cmd_t
module tep_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       command,
  input  tep_pkg::cfg_t    cfg,
  output logic             busy,
  output tep_pkg::dp_cmd_t cmd
);
  import tep_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WR
  } state_t;

  state_t               state, state_next;
  dir_t                 dir, dir_next;
  logic [X_BITS-1:0]    x, x_next;
  logic [Y_BITS-1:0]    y, y_next;
  logic [PASS_BITS-1:0] pass, pass_next;

  logic     accept;
  logic     w2, h2, no_work, pass_end, res_done;
  base_op_t base_op;
  dir_t     first_dir;

  always_comb begin
    accept    = start && !busy;
    w2        = cfg.width >= W_BITS'(2);
    h2        = cfg.height >= H_BITS'(2);
    no_work   = (cfg.passes == '0) || (cfg.width == '0) || (cfg.height == '0) || (!w2 && !h2);
    first_dir = w2 ? DIR_E : DIR_S;

    state_next = state;
    dir_next   = dir;
    x_next     = x;
    y_next     = y;
    pass_next  = pass;
    base_op    = BASE_HOLD;
    res_done   = 1'b0;
    pass_end   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_START) begin
          if (no_work) begin
            res_done = 1'b1;
          end else begin
            state_next = ST_RD;
            pass_next  = '0;
            x_next     = '0;
            y_next     = '0;
            dir_next   = first_dir;
            base_op    = BASE_CLEAR;
          end
        end
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        state_next = ST_RD;
        case (dir)
          DIR_E: begin
            if (W_BITS'(x) == cfg.width - W_BITS'(2)) begin
              dir_next = DIR_W;
              x_next   = X_BITS'(cfg.width - W_BITS'(1));
            end else begin
              x_next = x + X_BITS'(1);
            end
          end
          DIR_W: begin
            if (x == X_BITS'(1)) begin
              if (H_BITS'(y) == cfg.height - H_BITS'(1)) begin
                if (h2) begin
                  dir_next = DIR_S;
                  x_next   = '0;
                  y_next   = '0;
                  base_op  = BASE_CLEAR;
                end else begin
                  pass_end = 1'b1;
                end
              end else begin
                dir_next = DIR_E;
                x_next   = '0;
                y_next   = y + Y_BITS'(1);
                base_op  = BASE_ADD_W;
              end
            end else begin
              x_next = x - X_BITS'(1);
            end
          end
          DIR_S: begin
            if (H_BITS'(y) == cfg.height - H_BITS'(2)) begin
              dir_next = DIR_N;
            end
            y_next  = y + Y_BITS'(1);
            base_op = BASE_ADD_W;
          end
          DIR_N: begin
            if (y == Y_BITS'(1)) begin
              if (W_BITS'(x) == cfg.width - W_BITS'(1)) begin
                pass_end = 1'b1;
              end else begin
                dir_next = DIR_S;
                x_next   = x + X_BITS'(1);
                y_next   = '0;
                base_op  = BASE_SUB_W;
              end
            end else begin
              y_next  = y - Y_BITS'(1);
              base_op = BASE_SUB_W;
            end
          end
          default: ;
        endcase
        if (pass_end) begin
          if (pass == cfg.passes - PASS_BITS'(1)) begin
            state_next = ST_IDLE;
            res_done   = 1'b1;
          end else begin
            pass_next = pass + PASS_BITS'(1);
            x_next    = '0;
            y_next    = '0;
            dir_next  = first_dir;
            base_op   = BASE_CLEAR;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    cmd.load_we  = accept && command == CMD_LOAD;
    cmd.host_rd  = accept && command == CMD_READ;
    cmd.res_read = accept && command == CMD_READ;
    cmd.res_done = res_done;
    cmd.pad_rd   = state == ST_RD;
    cmd.pad_wr   = state == ST_WR;
    cmd.dir      = dir;
    cmd.base_op  = base_op;
    cmd.x        = x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      dir   <= DIR_E;
      x     <= '0;
      y     <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      busy  <= state_next != ST_IDLE;
      dir   <= dir_next;
      x     <= x_next;
      y     <= y_next;
      pass  <= pass_next;
    end
  end

endmodule

/* hdl/tep_dp.sv */
// tep_dp: pixel store with two read ports, sweep addressing, fill rule, result regs
// depends on tep_pkg; commanded by tep_ctrl
module tep_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tep_pkg::dp_cmd_t               cmd,
  input  tep_pkg::cfg_t                  cfg,
  input  logic [tep_pkg::INDEX_BITS-1:0] pixel_index,
  input  logic [tep_pkg::VALUE_BITS-1:0] pixel_value,
  output logic                           strobe,
  output logic                           result_kind,
  output logic [tep_pkg::VALUE_BITS-1:0] read_value
);
  import tep_pkg::*;

  logic [PIXEL_BITS-1:0] pixel_store [STORE_DEPTH];

  logic [ADDR_BITS-1:0]  base;
  logic [ADDR_BITS-1:0]  dst, src, host_addr, addr_a, waddr, w_ext;
  logic [PIXEL_BITS-1:0] rd_a, rd_b, wdata;
  logic                  in_range, we, rd_a_en, zero_out;

  always_comb begin
    w_ext     = ADDR_BITS'(cfg.width);
    host_addr = ADDR_BITS'(pixel_index);
    in_range  = int'(pixel_index) < STORE_DEPTH;
    dst       = base + ADDR_BITS'(cmd.x);
    case (cmd.dir)
      DIR_E:   src = dst + ADDR_BITS'(1);
      DIR_W:   src = dst - ADDR_BITS'(1);
      DIR_S:   src = dst + w_ext;
      DIR_N:   src = dst - w_ext;
      default: src = dst;
    endcase
    addr_a  = cmd.pad_rd ? dst : host_addr;
    rd_a_en = cmd.pad_rd || cmd.host_rd;
    we      = (cmd.load_we && in_range) || (cmd.pad_wr && rd_a == '0);
    waddr   = cmd.pad_wr ? dst : host_addr;
    wdata   = cmd.pad_wr ? (rd_b & cfg.keep) : pixel_value[PIXEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pixel_store[waddr] <= wdata;
    end
    if (rd_a_en) begin
      rd_a <= pixel_store[addr_a];
    end
    if (cmd.pad_rd) begin
      rd_b <= pixel_store[src];
    end
  end

  // row base y * width, stepped one row at a time
  always_ff @(posedge clk) begin
    case (cmd.base_op)
      BASE_CLEAR: base <= '0;
      BASE_ADD_W: base <= base + w_ext;
      BASE_SUB_W: base <= base - w_ext;
      default:    base <= base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.res_read || cmd.res_done;
    end
    result_kind <= cmd.res_done ? KIND_DONE : KIND_READ;
    zero_out    <= cmd.res_done || !in_range;
  end

  assign read_value = zero_out ? '0 : VALUE_BITS'(rd_a);

endmodule

/* hdl/texture_edge_padding.sv */
// texture_edge_padding: top level, a store of up to 128 by 128 pixel words that
// pads empty texels by dilation. Load and read commands are taken one per cycle
// while busy is low; a read answers on the cycle after it is accepted with strobe
// high for that single cycle, and a load answers nothing. Start runs pass_count
// passes, each sweeping rows east then west and columns south then north; each
// fill step reads the texel and its neighbor from the two-port store in ST_RD,
// then writes the texel conditionally in ST_WR. Start keeps busy high until the
// last pass ends and strobes the done result on the cycle busy falls. With no
// work to do the done result comes on the next cycle. The receiver has no way to
// stall: every strobe must be taken. The store needs no clearing after reset.
// Depends on tep_pkg, tep_regs, tep_ctrl, tep_dp.
module texture_edge_padding (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command,
  input  logic [tep_pkg::INDEX_BITS-1:0] pixel_index,
  input  logic [tep_pkg::VALUE_BITS-1:0] pixel_value,
  output logic                           strobe,
  output logic                           result_kind,
  output logic [tep_pkg::VALUE_BITS-1:0] read_value,
  input  logic                           write_enable,
  input  logic [1:0]                     reg_index,
  input  logic [tep_pkg::REG_BITS-1:0]   write_data
);
  import tep_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  tep_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  tep_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .cfg     (cfg),
    .busy    (busy),
    .cmd     (cmd)
  );

  tep_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .pixel_index (pixel_index),
    .pixel_value (pixel_value),
    .strobe      (strobe),
    .result_kind (result_kind),
    .read_value  (read_value)
  );

  // no result while a padding run is in progress
  assert property (@(posedge clk) disable iff (rst) busy |-> !strobe)
    else $error("result during padding run");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_READ) |=> (strobe && result_kind == KIND_READ))
    else $error("read item without read result");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command != CMD_START && command != CMD_READ) |=> !strobe)
    else $error("result from an item that gives none");

  assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind == KIND_DONE) |-> (read_value == '0 && !busy))
    else $error("malformed done result");

endmodule

/* test/texture_edge_padding_checker.sv */
`timescale 1ns / 1ps
// texture_edge_padding_checker: watches the command, register and result ports,
// keeps its own pixel store and registers, and scores every strobed result in order
// depends on tep_pkg
module texture_edge_padding_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     command,
  input  logic [tep_pkg::INDEX_BITS-1:0] pixel_index,
  input  logic [tep_pkg::VALUE_BITS-1:0] pixel_value,
  input  logic                           strobe,
  input  logic                           result_kind,
  input  logic [tep_pkg::VALUE_BITS-1:0] read_value,
  input  logic                           write_enable,
  input  logic [1:0]                     reg_index,
  input  logic [tep_pkg::REG_BITS-1:0]   write_data,
  output int                             mismatch_count,
  output int                             outstanding
);
  import tep_pkg::*;

  typedef struct {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
  } pad_result_t;

  logic [PIXEL_BITS-1:0] texel_mem [STORE_DEPTH];
  logic [7:0]            cfg_width;
  logic [7:0]            cfg_height;
  logic [31:0]           cfg_alpha;
  logic [PASS_BITS-1:0]  cfg_passes;
  pad_result_t           pad_results [$];
  pad_result_t           head;

  task automatic log_failure(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic fill_texel(input int dst, input int src, input logic [PIXEL_BITS-1:0] keep);
    if (texel_mem[dst] == '0) texel_mem[dst] = texel_mem[src] & keep;
  endtask

  task automatic dilate_texture();
    int w, h, p, x, y, base;
    logic [PIXEL_BITS-1:0] keep;
    w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
    h = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
    keep = ~cfg_alpha[PIXEL_BITS-1:0];
    if (w == 0 || h == 0) return;
    for (p = 0; p < cfg_passes; p++) begin
      for (y = 0; y < h; y++) begin
        base = y * w;
        for (x = 0; x + 1 < w; x++) fill_texel(base + x, base + x + 1, keep);
        for (x = w - 1; x > 0; x--) fill_texel(base + x, base + x - 1, keep);
      end
      for (x = 0; x < w; x++) begin
        for (y = 0; y + 1 < h; y++) fill_texel(y * w + x, (y + 1) * w + x, keep);
        for (y = h - 1; y > 0; y--) fill_texel(y * w + x, (y - 1) * w + x, keep);
      end
    end
  endtask

  task automatic apply_command();
    pad_result_t r;
    case (command)
      CMD_LOAD: texel_mem[pixel_index] = pixel_value[PIXEL_BITS-1:0];
      CMD_START: begin
        dilate_texture();
        r.kind = KIND_DONE;
        r.value = '0;
        pad_results.push_back(r);
      end
      CMD_READ: begin
        r.kind = KIND_READ;
        r.value = texel_mem[pixel_index];
        pad_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_alpha = ALPHA_RESET;
      cfg_passes = PASSES_RESET;
      pad_results.delete();
    end else begin
      if (strobe) begin
        if (pad_results.size() == 0) begin
          log_failure($sformatf("unexpected result: kind %0d value %h",
                                result_kind, read_value));
        end else begin
          head = pad_results.pop_front();
          if (head.kind !== result_kind || head.value !== read_value)
            log_failure($sformatf("mismatch: expected kind %0d value %h, got kind %0d value %h",
                                  head.kind, head.value, result_kind, read_value));
        end
      end
      if (write_enable) begin
        case (reg_index)
          REG_WIDTH:  cfg_width = write_data[7:0];
          REG_HEIGHT: cfg_height = write_data[7:0];
          REG_ALPHA:  cfg_alpha = write_data[31:0];
          REG_PASSES: cfg_passes = write_data[PASS_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) apply_command();
    end
    outstanding = pad_results.size();
  end

endmodule

/* test/texture_edge_padding_test.sv */
`timescale 1ns / 1ps
// texture_edge_padding_test: clock, reset and stimulus for texture_edge_padding,
// with the checker beside the block; depends on tep_pkg,
// texture_edge_padding and texture_edge_padding_checker
module texture_edge_padding_test;
  import tep_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 4000000;
  localparam int         RANDOM_ITEMS = 1400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [1:0]            command = CMD_LOAD;
  logic [INDEX_BITS-1:0] pixel_index = '0;
  logic [VALUE_BITS-1:0] pixel_value = '0;
  logic                  write_enable = 1'b0;
  logic [1:0]            reg_index = REG_WIDTH;
  logic [REG_BITS-1:0]   write_data = '0;
  logic                  busy;
  logic                  strobe;
  logic                  result_kind;
  logic [VALUE_BITS-1:0] read_value;

  int          mismatch_count;
  int          outstanding;
  int          cycle_count = 0;
  int          idle_pct = 18;
  int          items_sent = 0;
  int          region = 0;
  logic [31:0] alpha_cur = ALPHA_RESET;
  bit          loaded [STORE_DEPTH];
  int          loaded_list [$];

  always #5 clk = ~clk;

  texture_edge_padding uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .pixel_index(pixel_index), .pixel_value(pixel_value), .strobe(strobe),
    .result_kind(result_kind), .read_value(read_value), .write_enable(write_enable),
    .reg_index(reg_index), .write_data(write_data)
  );

  texture_edge_padding_checker pad_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .pixel_index(pixel_index), .pixel_value(pixel_value), .strobe(strobe),
    .result_kind(result_kind), .read_value(read_value), .write_enable(write_enable),
    .reg_index(reg_index), .write_data(write_data),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  function automatic logic [31:0] make_texel();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return 32'h0;
    if (pick == 5) return $urandom & alpha_cur;
    if (pick == 6) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input int idx, input logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    pixel_index <= idx[INDEX_BITS-1:0];
    pixel_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    if (cmd != CMD_UNUSED) items_sent++;
    idle_pct = (items_sent < RANDOM_ITEMS / 3) ? 18 :
               (items_sent < 2 * RANDOM_ITEMS / 3) ? 61 : 0;
  endtask

  // wait for every result, then for a load still in flight
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] w, input logic [7:0] h,
                           input logic [31:0] a, input logic [3:0] p);
    int ew, eh;
    settle();
    write_enable <= 1'b1;
    reg_index <= REG_WIDTH;
    write_data <= {24'($urandom_range(16777215)), w};
    @(negedge clk);
    reg_index <= REG_HEIGHT;
    write_data <= {24'($urandom_range(16777215)), h};
    @(negedge clk);
    reg_index <= REG_ALPHA;
    write_data <= a;
    @(negedge clk);
    reg_index <= REG_PASSES;
    write_data <= {28'($urandom_range(268435455)), p};
    @(negedge clk);
    write_enable <= 1'b0;
    ew = (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
    eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h);
    region = ew * eh;
    alpha_cur = a;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int          i, j, sel, pick, idx;
    logic [7:0]  w_v, h_v;
    logic [31:0] a_v;
    logic [3:0]  p_v;
    logic [31:0] small_img [6];

    small_img = '{32'h0000_1234, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0080};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // store extremes and an ignored command
    send_item(CMD_LOAD, 0, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, STORE_DEPTH - 1, 32'h8000_0001);
    send_item(CMD_LOAD, 14'h2AAA, 32'h5555_5555);
    send_item(CMD_LOAD, 14'h1555, 32'hAAAA_AAAA);
    send_item(CMD_UNUSED, 0, 32'h0);
    send_item(CMD_READ, 0, 32'h0);
    send_item(CMD_READ, STORE_DEPTH - 1, 32'h0);
    send_item(CMD_READ, 14'h2AAA, 32'h0);
    send_item(CMD_READ, 14'h1555, 32'h0);

    // small image with one pass
    configure(8'd3, 8'd2, 32'h0000_0080, 4'd1);
    for (i = 0; i < 6; i++) send_item(CMD_LOAD, i, small_img[i]);
    send_item(CMD_START, 0, 32'h0);
    send_item(CMD_READ, 1, 32'h0);
    send_item(CMD_READ, 3, 32'h0);
    send_item(CMD_READ, 4, 32'h0);

    // zero passes, then zero width
    configure(8'd3, 8'd2, 32'h0, 4'd0);
    send_item(CMD_START, 0, 32'h0);
    configure(8'd0, 8'd2, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_START, 0, 32'h0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(19);
      w_v = 8'($urandom_range(8, 1));
      h_v = 8'($urandom_range(8, 1));
      p_v = ($urandom_range(4) == 0) ? 4'd15 : 4'($urandom_range(3));
      if (sel == 0) begin
        w_v = $urandom_range(1) ? 8'd128 : 8'($urandom_range(255, 129));
        h_v = 8'($urandom_range(2, 1));
        p_v = 4'($urandom_range(3));
      end else if (sel == 1) begin
        h_v = $urandom_range(1) ? 8'd128 : 8'($urandom_range(255, 129));
        w_v = 8'($urandom_range(2, 1));
        p_v = 4'($urandom_range(3));
      end else if (sel == 2) begin
        if ($urandom_range(1)) w_v = 8'd0;
        else h_v = 8'd0;
      end else if (sel == 3) begin
        w_v = 8'd1;
      end else if (sel == 4) begin
        h_v = 8'd1;
      end
      case ($urandom_range(5))
        0: a_v = 32'h0;
        1: a_v = 32'hFFFF_FFFF;
        2: a_v = 32'h0000_00FF;
        3: a_v = 32'h0000_0080;
        4: a_v = 32'hFF00_0000;
        default: a_v = $urandom;
      endcase
      configure(w_v, h_v, a_v, p_v);

      // fresh image content, then pad it
      for (i = 0; i < region; i++) send_item(CMD_LOAD, i, make_texel());
      send_item(CMD_START, $urandom_range(STORE_DEPTH - 1), $urandom);

      for (j = 0; j < 30; j++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          if (region > 0 && $urandom_range(1)) idx = $urandom_range(region - 1);
          else idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
          send_item(CMD_READ, idx, $urandom);
        end else if (pick < 75) begin
          if (region > 0 && $urandom_range(1)) idx = $urandom_range(region - 1);
          else idx = $urandom_range(STORE_DEPTH - 1);
          send_item(CMD_LOAD, idx, make_texel());
        end else if (pick < 85) begin
          send_item(CMD_START, $urandom_range(STORE_DEPTH - 1), $urandom);
        end else begin
          send_item(CMD_UNUSED, $urandom_range(STORE_DEPTH - 1), $urandom);
        end
      end
    end

    settle();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
